>>> design/fbpe_pkg.sv
// Shared constants, codes and helpers for the framebuffer pixel engine.
// No dependencies; used by framebuffer_pixel_engine_top.
`timescale 1ns / 1ps
`default_nettype none
package fbpe_pkg;

    localparam int STORE_BYTES = 32768;
    localparam int MAX_DIM     = 1024;

    localparam int COORD_W  = 11;
    localparam int STRIDE_W = 12;
    localparam int OFF_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // two byte banks: even and odd byte addresses
    localparam int BANK_DEPTH = STORE_BYTES / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 96;

    localparam logic [1:0] FMT_HMONO  = 2'd0;
    localparam logic [1:0] FMT_VMONO  = 2'd1;
    localparam logic [1:0] FMT_GRAY8  = 2'd2;
    localparam logic [1:0] FMT_RGB565 = 2'd3;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_DIRTY = 2'd2;
    localparam logic [1:0] REQ_FULL  = 2'd3;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_CLIP  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_W    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_H    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_W  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_H  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y = 3'd7;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_ROT   = 8'b0000_0100,
        S_SCR   = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_ADDR  = 8'b0010_0000,
        S_READ  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    // zero acts as 1, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [COORD_W-1:0] clamp_dim(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v == '0)
        begin
            r = COORD_W'(1);
        end
        else if (v > COORD_W'(MAX_DIM))
        begin
            r = COORD_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/fbpe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fbpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> design/framebuffer_pixel_engine_top.sv
// Framebuffer pixel engine: coordinate mapping, byte framebuffer access, dirty box.
// Depends on fbpe_pkg and fbpe_ram.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+------------------------------------
//  s_axis    | s_axis_tvalid / s_axis_tready | tdata: view_x, view_y, pen_color
//            |                               | tuser: req_type
//  m_axis    | m_axis_tvalid / m_axis_tready | tdata: status .. row_stride
//  cfg       | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One item at a time: an accepted item passes the map, scroll, multiply, address and
// memory read steps, its result is registered in the write-back step, and the next
// item is accepted only once the engine is back in idle.
// After reset the framebuffer banks are cleared one word per cycle;
// no item is accepted meanwhile, configuration writes are always taken.
// A result waits in the output register; write-back stalls until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module framebuffer_pixel_engine_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [9:0] view_x, [19:10] view_y, [35:20] pen_color, rest zero
    input  wire logic [fbpe_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] req_type
    input  wire logic [fbpe_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [1:0] status, [17:2] pixel_value, [28:18] region_x, [39:29] region_y,
    // [50:40] region_w, [61:51] region_h, [76:62] start_offset,
    // [88:77] row_stride, rest zero
    output logic      [fbpe_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fbpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fbpe_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW = fbpe_pkg::COORD_W;
    localparam int OW = fbpe_pkg::OFF_W;
    localparam int SW = fbpe_pkg::STRIDE_W;
    localparam int AW = fbpe_pkg::BANK_AW;

    fbpe_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [fbpe_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [1:0]    format_reg, format_next;
    logic [1:0]    rotation_reg, rotation_next;
    logic [CW-1:0] mem_w_reg, mem_w_next;
    logic [CW-1:0] mem_h_reg, mem_h_next;
    logic [CW-1:0] panel_w_reg, panel_w_next;
    logic [CW-1:0] panel_h_reg, panel_h_next;
    logic [9:0]    scroll_x_reg, scroll_x_next;
    logic [9:0]    scroll_y_reg, scroll_y_next;

    logic          dirty_valid_reg, dirty_valid_next;
    logic [CW-1:0] dirty_l_reg, dirty_l_next;
    logic [CW-1:0] dirty_t_reg, dirty_t_next;
    logic [CW-1:0] dirty_w_reg, dirty_w_next;
    logic [CW-1:0] dirty_h_reg, dirty_h_next;

    logic [1:0]    req_reg, req_next;
    logic [9:0]    vx_reg, vx_next;
    logic [9:0]    vy_reg, vy_next;
    logic [15:0]   pen_reg, pen_next;
    logic [CW-1:0] rot_x_reg, rot_x_next;
    logic [CW-1:0] rot_y_reg, rot_y_next;
    logic          clip_reg, clip_next;
    logic [CW-1:0] rx_reg, rx_next;
    logic [CW-1:0] ry_reg, ry_next;
    logic [CW:0]   xlim_reg, xlim_next;
    logic [CW:0]   ylim_reg, ylim_next;
    logic [CW-1:0] rw_reg, rw_next;
    logic [CW-1:0] rh_reg, rh_next;
    logic [CW-1:0] cx_reg, cx_next;
    logic [CW-1:0] cy_reg, cy_next;
    logic [OW-1:0] prod_reg, prod_next;
    logic [SW-1:0] xterm_reg, xterm_next;
    logic [OW-1:0] idx_reg, idx_next;
    logic          oob_reg, oob_next;

    logic          ram_we0, ram_we1, ram_re;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata0, ram_wdata1, ram_rdata0, ram_rdata1;

    logic [CW-1:0] mw, mh, pw, ph, vw, vh;
    logic [CW-1:0] sx, sy;
    logic [SW-1:0] stride;
    logic          is_pixel;

    always_comb
    begin
        mw = fbpe_pkg::clamp_dim(mem_w_reg);
        mh = fbpe_pkg::clamp_dim(mem_h_reg);
        pw = fbpe_pkg::clamp_dim(panel_w_reg);
        ph = fbpe_pkg::clamp_dim(panel_h_reg);
        vw = rotation_reg[0] ? ph : pw;
        vh = rotation_reg[0] ? pw : ph;
        sx = {1'b0, scroll_x_reg};
        sy = {1'b0, scroll_y_reg};
        unique case (format_reg)
            fbpe_pkg::FMT_HMONO:  stride = SW'((mw + CW'(7)) >> 3);
            fbpe_pkg::FMT_RGB565: stride = {mw, 1'b0};
            default:              stride = SW'(mw);
        endcase
        is_pixel = (req_reg == fbpe_pkg::REQ_WRITE) || (req_reg == fbpe_pkg::REQ_READ);
    end

    logic [CW-1:0] vx11, vy11;
    logic [CW:0]   sum_x, sum_y, diff_w, diff_h, xe, ye, mw12, mh12;
    logic [CW-1:0] aw_full, ah_full;
    logic [CW-1:0] yterm;
    logic [OW-1:0] idx_sum;
    logic [7:0]    sel_byte, bit_mask, mod_byte;
    logic [2:0]    bit_n;
    logic          pix_ok, query_empty;
    logic [CW:0]   gr_r, gr_b, gr_l, gr_t;
    logic [1:0]    o_status;
    logic [15:0]   o_pixel;
    logic [CW-1:0] o_rx, o_ry, o_rw, o_rh;
    logic [14:0]   o_off;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        format_next      = format_reg;
        rotation_next    = rotation_reg;
        mem_w_next       = mem_w_reg;
        mem_h_next       = mem_h_reg;
        panel_w_next     = panel_w_reg;
        panel_h_next     = panel_h_reg;
        scroll_x_next    = scroll_x_reg;
        scroll_y_next    = scroll_y_reg;
        dirty_valid_next = dirty_valid_reg;
        dirty_l_next     = dirty_l_reg;
        dirty_t_next     = dirty_t_reg;
        dirty_w_next     = dirty_w_reg;
        dirty_h_next     = dirty_h_reg;
        req_next   = req_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        pen_next   = pen_reg;
        rot_x_next = rot_x_reg;
        rot_y_next = rot_y_reg;
        clip_next  = clip_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        xlim_next  = xlim_reg;
        ylim_next  = ylim_reg;
        rw_next    = rw_reg;
        rh_next    = rh_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        prod_next  = prod_reg;
        xterm_next = xterm_reg;
        idx_next   = idx_reg;
        oob_next   = oob_reg;

        ram_we0    = 1'b0;
        ram_we1    = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = idx_reg[AW:1];
        ram_wdata0 = '0;
        ram_wdata1 = '0;

        vx11   = {1'b0, vx_reg};
        vy11   = {1'b0, vy_reg};
        mw12   = {1'b0, mw};
        mh12   = {1'b0, mh};
        sum_x  = {1'b0, rot_x_reg} + {1'b0, sx};
        sum_y  = {1'b0, rot_y_reg} + {1'b0, sy};
        diff_w = (xlim_reg > {1'b0, rx_reg}) ? xlim_reg - {1'b0, rx_reg} : '0;
        diff_h = (ylim_reg > {1'b0, ry_reg}) ? ylim_reg - {1'b0, ry_reg} : '0;
        xe     = {1'b0, dirty_l_reg} + {1'b0, dirty_w_reg};
        ye     = {1'b0, dirty_t_reg} + {1'b0, dirty_h_reg};
        aw_full = (mw > sx) ? mw - sx : '0;
        ah_full = (mh > sy) ? mh - sy : '0;
        yterm   = (format_reg == fbpe_pkg::FMT_VMONO) ? (cy_reg >> 3) : cy_reg;
        idx_sum = prod_reg + OW'(xterm_reg);

        sel_byte = idx_reg[0] ? ram_rdata1 : ram_rdata0;
        bit_n    = (format_reg == fbpe_pkg::FMT_HMONO) ? ~cx_reg[2:0] : cy_reg[2:0];
        bit_mask = 8'd1 << bit_n;
        mod_byte = (pen_reg != '0) ? (sel_byte | bit_mask) : (sel_byte & ~bit_mask);
        pix_ok   = is_pixel && !clip_reg && !oob_reg;
        query_empty = (req_reg == fbpe_pkg::REQ_DIRTY) && !dirty_valid_reg;

        gr_r = {1'b0, dirty_l_reg} + {1'b0, dirty_w_reg} - ((dirty_w_reg != '0) ? 12'd1 : 12'd0);
        gr_b = {1'b0, dirty_t_reg} + {1'b0, dirty_h_reg} - ((dirty_h_reg != '0) ? 12'd1 : 12'd0);
        gr_l = ({1'b0, cx_reg} < {1'b0, dirty_l_reg}) ? {1'b0, cx_reg} : {1'b0, dirty_l_reg};
        gr_t = ({1'b0, cy_reg} < {1'b0, dirty_t_reg}) ? {1'b0, cy_reg} : {1'b0, dirty_t_reg};
        if ({1'b0, cx_reg} > gr_r)
        begin
            gr_r = {1'b0, cx_reg};
        end
        if ({1'b0, cy_reg} > gr_b)
        begin
            gr_b = {1'b0, cy_reg};
        end

        o_status = fbpe_pkg::STAT_DONE;
        o_pixel  = '0;
        o_rx     = '0;
        o_ry     = '0;
        o_rw     = '0;
        o_rh     = '0;
        o_off    = '0;
        if (is_pixel)
        begin
            if (!pix_ok)
            begin
                o_status = fbpe_pkg::STAT_CLIP;
            end
            else if (req_reg == fbpe_pkg::REQ_READ)
            begin
                case (format_reg) inside
                    fbpe_pkg::FMT_HMONO, fbpe_pkg::FMT_VMONO:
                        o_pixel = {15'd0, sel_byte[bit_n]};
                    fbpe_pkg::FMT_GRAY8:
                        o_pixel = {8'd0, sel_byte};
                    default:
                        o_pixel = {ram_rdata1, ram_rdata0};
                endcase
            end
        end
        else if (query_empty)
        begin
            o_status = fbpe_pkg::STAT_EMPTY;
        end
        else
        begin
            o_status = oob_reg ? fbpe_pkg::STAT_CLIP : fbpe_pkg::STAT_DONE;
            o_rx     = rx_reg;
            o_ry     = ry_reg;
            o_rw     = rw_reg;
            o_rh     = rh_reg;
            o_off    = idx_reg[14:0];
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                fbpe_pkg::CFG_FORMAT:   format_next   = cfg_data[1:0];
                fbpe_pkg::CFG_ROTATION: rotation_next = cfg_data[1:0];
                fbpe_pkg::CFG_MEM_W:    mem_w_next    = cfg_data;
                fbpe_pkg::CFG_MEM_H:    mem_h_next    = cfg_data;
                fbpe_pkg::CFG_PANEL_W:  panel_w_next  = cfg_data;
                fbpe_pkg::CFG_PANEL_H:  panel_h_next  = cfg_data;
                fbpe_pkg::CFG_SCROLL_X: scroll_x_next = cfg_data[9:0];
                fbpe_pkg::CFG_SCROLL_Y: scroll_y_next = cfg_data[9:0];
                default: ;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            fbpe_pkg::S_CLEAR:
            begin
                ram_we0   = 1'b1;
                ram_we1   = 1'b1;
                ram_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(fbpe_pkg::BANK_DEPTH - 1))
                begin
                    state_next = fbpe_pkg::S_IDLE;
                end
            end
            fbpe_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next   = s_axis_tuser[1:0];
                    vx_next    = s_axis_tdata[9:0];
                    vy_next    = s_axis_tdata[19:10];
                    pen_next   = s_axis_tdata[35:20];
                    state_next = fbpe_pkg::S_ROT;
                end
            end
            fbpe_pkg::S_ROT:
            begin
                // pixel: rotate into panel space; queries: region corner and limit
                clip_next = is_pixel && ((vx11 >= vw) || (vy11 >= vh));
                unique case (rotation_reg)
                    fbpe_pkg::ROT_90:
                    begin
                        rot_x_next = pw - CW'(1) - vy11;
                        rot_y_next = vx11;
                    end
                    fbpe_pkg::ROT_180:
                    begin
                        rot_x_next = pw - CW'(1) - vx11;
                        rot_y_next = ph - CW'(1) - vy11;
                    end
                    fbpe_pkg::ROT_270:
                    begin
                        rot_x_next = vy11;
                        rot_y_next = ph - CW'(1) - vx11;
                    end
                    default:
                    begin
                        rot_x_next = vx11;
                        rot_y_next = vy11;
                    end
                endcase
                if (req_reg == fbpe_pkg::REQ_DIRTY)
                begin
                    rx_next   = (dirty_l_reg > sx) ? dirty_l_reg - sx : '0;
                    ry_next   = (dirty_t_reg > sy) ? dirty_t_reg - sy : '0;
                    xlim_next = (xe < mw12) ? xe : mw12;
                    ylim_next = (ye < mh12) ? ye : mh12;
                end
                else
                begin
                    rx_next   = '0;
                    ry_next   = '0;
                    xlim_next = {1'b0, (pw < aw_full) ? pw : aw_full};
                    ylim_next = {1'b0, (ph < ah_full) ? ph : ah_full};
                end
                state_next = fbpe_pkg::S_SCR;
            end
            fbpe_pkg::S_SCR:
            begin
                if (is_pixel)
                begin
                    clip_next = clip_reg || (sum_x >= mw12) || (sum_y >= mh12);
                    cx_next   = sum_x[CW-1:0];
                    cy_next   = sum_y[CW-1:0];
                end
                else
                begin
                    rw_next = diff_w[CW-1:0];
                    rh_next = diff_h[CW-1:0];
                    cx_next = rx_reg + sx;
                    cy_next = ry_reg + sy;
                end
                state_next = fbpe_pkg::S_MUL;
            end
            fbpe_pkg::S_MUL:
            begin
                prod_next = OW'(yterm) * OW'(stride);
                unique case (format_reg)
                    fbpe_pkg::FMT_HMONO:  xterm_next = SW'(cx_reg >> 3);
                    fbpe_pkg::FMT_RGB565: xterm_next = {cx_reg, 1'b0};
                    default:              xterm_next = SW'(cx_reg);
                endcase
                state_next = fbpe_pkg::S_ADDR;
            end
            fbpe_pkg::S_ADDR:
            begin
                idx_next = idx_sum;
                oob_next = (idx_sum >= OW'(fbpe_pkg::STORE_BYTES))
                        || (is_pixel && (format_reg == fbpe_pkg::FMT_RGB565)
                            && (idx_sum == OW'(fbpe_pkg::STORE_BYTES - 1)));
                state_next = fbpe_pkg::S_READ;
            end
            fbpe_pkg::S_READ:
            begin
                ram_re     = 1'b1;
                state_next = fbpe_pkg::S_DONE;
            end
            fbpe_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0, stride, o_off, o_rh, o_rw, o_ry, o_rx,
                                      o_pixel, o_status};
                    if (pix_ok && (req_reg == fbpe_pkg::REQ_WRITE))
                    begin
                        case (format_reg) inside
                            fbpe_pkg::FMT_HMONO, fbpe_pkg::FMT_VMONO:
                            begin
                                ram_we0    = !idx_reg[0];
                                ram_we1    = idx_reg[0];
                                ram_wdata0 = mod_byte;
                                ram_wdata1 = mod_byte;
                            end
                            fbpe_pkg::FMT_GRAY8:
                            begin
                                ram_we0    = !idx_reg[0];
                                ram_we1    = idx_reg[0];
                                ram_wdata0 = pen_reg[7:0];
                                ram_wdata1 = pen_reg[7:0];
                            end
                            default:
                            begin
                                ram_we0    = 1'b1;
                                ram_we1    = 1'b1;
                                ram_wdata0 = pen_reg[7:0];
                                ram_wdata1 = pen_reg[15:8];
                            end
                        endcase
                        dirty_valid_next = 1'b1;
                        if (!dirty_valid_reg)
                        begin
                            dirty_l_next = cx_reg;
                            dirty_t_next = cy_reg;
                            dirty_w_next = CW'(1);
                            dirty_h_next = CW'(1);
                        end
                        else
                        begin
                            dirty_l_next = gr_l[CW-1:0];
                            dirty_t_next = gr_t[CW-1:0];
                            dirty_w_next = CW'(gr_r - gr_l + 12'd1);
                            dirty_h_next = CW'(gr_b - gr_t + 12'd1);
                        end
                    end
                    else if (!is_pixel && !query_empty)
                    begin
                        dirty_valid_next = 1'b0;
                    end
                    state_next = fbpe_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fbpe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fbpe_pkg::S_CLEAR;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            format_reg      <= fbpe_pkg::FMT_HMONO;
            rotation_reg    <= fbpe_pkg::ROT_0;
            mem_w_reg       <= CW'(128);
            mem_h_reg       <= CW'(64);
            panel_w_reg     <= CW'(128);
            panel_h_reg     <= CW'(64);
            scroll_x_reg    <= '0;
            scroll_y_reg    <= '0;
            dirty_valid_reg <= 1'b0;
            dirty_l_reg     <= '0;
            dirty_t_reg     <= '0;
            dirty_w_reg     <= '0;
            dirty_h_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            out_valid_reg   <= out_valid_next;
            format_reg      <= format_next;
            rotation_reg    <= rotation_next;
            mem_w_reg       <= mem_w_next;
            mem_h_reg       <= mem_h_next;
            panel_w_reg     <= panel_w_next;
            panel_h_reg     <= panel_h_next;
            scroll_x_reg    <= scroll_x_next;
            scroll_y_reg    <= scroll_y_next;
            dirty_valid_reg <= dirty_valid_next;
            dirty_l_reg     <= dirty_l_next;
            dirty_t_reg     <= dirty_t_next;
            dirty_w_reg     <= dirty_w_next;
            dirty_h_reg     <= dirty_h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        req_reg      <= req_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        pen_reg      <= pen_next;
        rot_x_reg    <= rot_x_next;
        rot_y_reg    <= rot_y_next;
        clip_reg     <= clip_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        xlim_reg     <= xlim_next;
        ylim_reg     <= ylim_next;
        rw_reg       <= rw_next;
        rh_reg       <= rh_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        prod_reg     <= prod_next;
        xterm_reg    <= xterm_next;
        idx_reg      <= idx_next;
        oob_reg      <= oob_next;
    end

    fbpe_ram #(
        .WIDTH (8),
        .DEPTH (fbpe_pkg::BANK_DEPTH)
    ) u_bank_even (
        .clk   (clk),
        .we    (ram_we0),
        .waddr (ram_waddr),
        .wdata (ram_wdata0),
        .re    (ram_re),
        .raddr (idx_reg[AW:1]),
        .rdata (ram_rdata0)
    );

    fbpe_ram #(
        .WIDTH (8),
        .DEPTH (fbpe_pkg::BANK_DEPTH)
    ) u_bank_odd (
        .clk   (clk),
        .we    (ram_we1),
        .waddr (ram_waddr),
        .wdata (ram_wdata1),
        .re    (ram_re),
        .raddr (idx_reg[AW:1]),
        .rdata (ram_rdata1)
    );

    assign s_axis_tready = (state_reg == fbpe_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    a_we_only_clear_or_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we0 || ram_we1) |->
            (state_reg == fbpe_pkg::S_CLEAR || state_reg == fbpe_pkg::S_DONE))
        else $error("framebuffer written outside clear or write-back");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == fbpe_pkg::S_DONE))
        else $error("result raised without write-back step");

    a_dirty_box_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        dirty_valid_reg |-> (dirty_w_reg != '0 && dirty_h_reg != '0))
        else $error("dirty box valid with zero size");

    a_accept_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == fbpe_pkg::S_ROT))
        else $error("accepted item did not enter mapping");

endmodule
`default_nettype wire
